// ===== rtl/core/fbpa_pkg.sv =====
// ---------------------------------------------------------------------------
// fbpa_pkg
// Shared types and constants for the fixed block pool allocator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package fbpa_pkg;

  localparam int unsigned AddrW  = 48;
  localparam int unsigned ShiftW = 5;
  localparam int unsigned CountW = 11;
  localparam int unsigned CfgIdxW = 2;

  // Stride clamp limits (log2 of bytes)
  localparam logic [ShiftW-1:0] ShiftMin = ShiftW'(3);
  localparam logic [ShiftW-1:0] ShiftMax = ShiftW'(16);

  // Register indexes on the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    REG_POOL_BASE   = 2'd0,
    REG_STRIDE_LOG2 = 2'd1,
    REG_BLOCK_COUNT = 2'd2
  } reg_idx_e;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_EMPTY   = 2'd1,
    STATUS_INVALID = 2'd2,
    STATUS_DOUBLE  = 2'd3
  } status_e;

  // Controller to datapath commands
  typedef struct packed {
    logic sweep_start;  // restart the clearing sweep at entry zero
    logic sweep;        // clear one memory entry, reload the pool counters
    logic accept;       // input transfer: capture item, start memory read
    logic exec;         // finish item: update stack, load result register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic cfg_restart;  // register write that restarts the pool
    logic sweep_last;   // sweep is at the last memory entry
  } sts_t;

endpackage

// ===== rtl/core/fixed_block_pool_allocator.sv =====
// ---------------------------------------------------------------------------
// fixed_block_pool_allocator
// Fixed-size block pool with a LIFO free list: allocate and free requests.
// ---------------------------------------------------------------------------
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+------------------------------
//  in      | input     | in_valid_i / in_ready_o  | mode_i, free_address_i
//  out     | output    | out_valid_o / out_ready_i| status_o, block_address_o,
//          |           |                          | blocks_free_o
//  cfg     | input     | cfg_we_i (no wait)       | cfg_index_i, cfg_wdata_i
//
// Each item is accepted with a block memory read, then finished with a stack
// update, memory write and result load once the read data is registered.
// After reset and after each write to a defined register the block memory is
// swept, every entry cleared, with in_ready_o low. A new item is taken while a
// result waits; the finish step stalls until the result register is free.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fixed_block_pool_allocator #(
  parameter int unsigned MAX_BLOCKS = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [fbpa_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [fbpa_pkg::AddrW-1:0]   cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         mode_i,
  input  logic [fbpa_pkg::AddrW-1:0]   free_address_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [1:0]                   status_o,
  output logic [fbpa_pkg::AddrW-1:0]   block_address_o,
  output logic [fbpa_pkg::CountW-1:0]  blocks_free_o
);
  import fbpa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  fbpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  fbpa_dp #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .mode_i          (mode_i),
    .free_address_i  (free_address_i),
    .status_o        (status_o),
    .block_address_o (block_address_o),
    .blocks_free_o   (blocks_free_o),
    .cmd_i           (cmd),
    .sts_o           (sts)
  );

endmodule

// ===== rtl/core/fbpa_ram.sv =====
// ---------------------------------------------------------------------------
// fbpa_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fbpa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/fbpa_ctrl.sv =====
// ---------------------------------------------------------------------------
// fbpa_ctrl
// Sequencer: clearing sweep, item accept, item finish and result valid.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fbpa_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  fbpa_pkg::sts_t sts_i,
  output fbpa_pkg::cmd_t cmd_o
);
  import fbpa_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  // result register can take a new result this cycle
  assign slot_free = !out_valid_q || out_ready_i;

  // command decode and next state
  always_comb begin
    state_d            = state_q;
    out_valid_d        = out_valid_q && !out_ready_i;
    cmd_o              = '0;
    cmd_o.sweep_start  = sts_i.cfg_restart;
    unique case (state_q)
      ST_CLEAR: begin
        if (!sts_i.cfg_restart) begin
          cmd_o.sweep = 1'b1;
          if (sts_i.sweep_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (slot_free) begin
          cmd_o.exec  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
    // a restarting register write always returns to the sweep
    if (sts_i.cfg_restart) begin
      state_d = ST_CLEAR;
    end
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/core/fbpa_dp.sv =====
// ---------------------------------------------------------------------------
// fbpa_dp
// Datapath: registers, address check, free stack, block memory, result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fbpa_dp #(
  parameter int unsigned MAX_BLOCKS = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [fbpa_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [fbpa_pkg::AddrW-1:0]          cfg_wdata_i,
  input  logic                                mode_i,
  input  logic [fbpa_pkg::AddrW-1:0]          free_address_i,
  output logic [1:0]                          status_o,
  output logic [fbpa_pkg::AddrW-1:0]          block_address_o,
  output logic [fbpa_pkg::CountW-1:0]         blocks_free_o,
  input  fbpa_pkg::cmd_t                      cmd_i,
  output fbpa_pkg::sts_t                      sts_o
);
  import fbpa_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_BLOCKS);
  localparam int unsigned CntW = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned MemW = IdxW + 1;  // busy bit over link index

  // configuration registers
  logic [AddrW-1:0]  pool_base_q;
  logic [ShiftW-1:0] stride_log2_q;
  logic [CountW-1:0] block_count_q;
  logic              cfg_hit;

  always_comb begin
    case (cfg_index_i)
      REG_POOL_BASE, REG_STRIDE_LOG2, REG_BLOCK_COUNT: cfg_hit = 1'b1;
      default:                                          cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_base_q   <= '0;
      stride_log2_q <= ShiftW'(6);
      block_count_q <= CountW'(1024);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_POOL_BASE:   pool_base_q   <= cfg_wdata_i;
        REG_STRIDE_LOG2: stride_log2_q <= cfg_wdata_i[ShiftW-1:0];
        REG_BLOCK_COUNT: block_count_q <= cfg_wdata_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  // effective pool geometry
  logic [ShiftW-1:0] shift_eff;
  logic [CntW-1:0]   count_eff;
  logic [AddrW-1:0]  stride_mask;
  logic [AddrW-1:0]  base_eff;
  logic [AddrW:0]    pool_end_q;

  always_comb begin
    if (stride_log2_q < ShiftMin)      shift_eff = ShiftMin;
    else if (stride_log2_q > ShiftMax) shift_eff = ShiftMax;
    else                               shift_eff = stride_log2_q;
    if (32'(block_count_q) > 32'(MAX_BLOCKS)) count_eff = CntW'(MAX_BLOCKS);
    else                                      count_eff = CntW'(block_count_q);
  end

  assign stride_mask = (AddrW'(1) << shift_eff) - AddrW'(1);
  assign base_eff    = pool_base_q & ~stride_mask;

  // clearing sweep counter
  logic [IdxW-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.sweep_start) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.sweep) begin
      clr_cnt_q <= clr_cnt_q + IdxW'(1);
    end
  end

  // pool end is reloaded while sweeping, stable afterwards
  always_ff @(posedge clk_i) begin
    if (cmd_i.sweep) begin
      pool_end_q <= {1'b0, base_eff} + ((AddrW+1)'(count_eff) << shift_eff);
    end
  end

  assign sts_o.cfg_restart = cfg_we_i && cfg_hit;
  assign sts_o.sweep_last  = (clr_cnt_q == IdxW'(MAX_BLOCKS - 1));

  // free stack and counters
  logic [IdxW-1:0] freed_top_q, freed_top_d;
  logic            freed_valid_q, freed_valid_d;
  logic [CntW-1:0] fresh_q, fresh_d;
  logic [CntW-1:0] total_q, total_d;

  // check of the address to free
  logic [AddrW:0]   diff;
  logic             addr_ok;
  logic [AddrW-1:0] free_off;
  logic [IdxW-1:0]  free_idx;

  assign diff     = {1'b0, free_address_i} - {1'b0, base_eff};
  assign addr_ok  = (free_address_i != '0) && !diff[AddrW]
                    && ({1'b0, free_address_i} < pool_end_q)
                    && ((free_address_i & stride_mask) == '0);
  assign free_off = diff[AddrW-1:0] >> shift_eff;
  assign free_idx = free_off[IdxW-1:0];

  // allocation source
  logic            alloc_got;
  logic [IdxW-1:0] alloc_idx;
  logic [CntW-1:0] fresh_dec;

  assign fresh_dec = fresh_q - CntW'(1);
  assign alloc_got = freed_valid_q || (fresh_q != '0);
  assign alloc_idx = freed_valid_q ? freed_top_q : fresh_dec[IdxW-1:0];

  // item captured at the input transfer
  logic            op_alloc_q;
  logic            op_got_q;
  logic            op_from_freed_q;
  logic            op_addr_ok_q;
  logic [IdxW-1:0] op_idx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_alloc_q      <= !mode_i;
      op_got_q        <= alloc_got;
      op_from_freed_q <= freed_valid_q;
      op_addr_ok_q    <= addr_ok;
      op_idx_q        <= mode_i ? free_idx : alloc_idx;
    end
  end

  // block memory: busy bit and link to the next freed block
  logic            ram_we;
  logic [IdxW-1:0] ram_waddr;
  logic [MemW-1:0] ram_wdata;
  logic [MemW-1:0] ram_rdata;
  logic            rd_busy;
  logic [IdxW-1:0] rd_link;

  assign rd_busy = ram_rdata[IdxW];
  assign rd_link = ram_rdata[IdxW-1:0];

  fbpa_ram #(
    .WIDTH (MemW),
    .DEPTH (MAX_BLOCKS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.accept),
    .raddr_i (mode_i ? free_idx : alloc_idx),
    .rdata_o (ram_rdata)
  );

  // item finish: stack update, memory write, result
  status_e          res_status;
  logic [AddrW-1:0] res_addr;
  logic [AddrW-1:0] blk_addr;

  assign blk_addr = base_eff + (AddrW'(op_idx_q) << shift_eff);

  always_comb begin
    freed_top_d   = freed_top_q;
    freed_valid_d = freed_valid_q;
    fresh_d       = fresh_q;
    total_d       = total_q;
    ram_we        = 1'b0;
    ram_waddr     = clr_cnt_q;
    ram_wdata     = '0;
    res_status    = STATUS_OK;
    res_addr      = '0;
    if (cmd_i.sweep) begin
      ram_we        = 1'b1;
      freed_top_d   = '0;
      freed_valid_d = 1'b0;
      fresh_d       = count_eff;
      total_d       = count_eff;
    end else if (cmd_i.exec) begin
      ram_waddr = op_idx_q;
      if (op_alloc_q) begin
        if (op_got_q) begin
          ram_we    = 1'b1;
          ram_wdata = {1'b1, rd_link};
          total_d   = total_q - CntW'(1);
          res_addr  = blk_addr;
          if (op_from_freed_q) begin
            freed_top_d   = rd_link;
            freed_valid_d = (total_d > fresh_q);
          end else begin
            fresh_d = fresh_dec;
          end
        end else begin
          res_status = STATUS_EMPTY;
        end
      end else if (!op_addr_ok_q) begin
        res_status = STATUS_INVALID;
      end else if (!rd_busy) begin
        res_status = STATUS_DOUBLE;
      end else begin
        ram_we        = 1'b1;
        ram_wdata     = {1'b0, freed_top_q};
        freed_top_d   = op_idx_q;
        freed_valid_d = 1'b1;
        total_d       = total_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freed_top_q   <= '0;
      freed_valid_q <= 1'b0;
      fresh_q       <= '0;
      total_q       <= '0;
    end else begin
      freed_top_q   <= freed_top_d;
      freed_valid_q <= freed_valid_d;
      fresh_q       <= fresh_d;
      total_q       <= total_d;
    end
  end

  // result register
  logic [1:0]        out_status_q;
  logic [AddrW-1:0]  out_addr_q;
  logic [CountW-1:0] out_free_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      out_status_q <= res_status;
      out_addr_q   <= res_addr;
      out_free_q   <= CountW'(total_d);
    end
  end

  assign status_o        = out_status_q;
  assign block_address_o = out_addr_q;
  assign blocks_free_o   = out_free_q;

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the fixed block pool allocator. A queue-fed driver
// sends allocate and free requests, a shadow pool computes the status,
// address and free count of each one, and a monitor compares every result.
// Directed corner cases run first, then random phases under varied pool
// settings, random idle cycles and back-pressure on both sides.
// ---------------------------------------------------------------------------

module tb;
  import fbpa_pkg::*;

  localparam int unsigned MaxBlocks = 1024;
  localparam logic ModeAlloc = 1'b0;
  localparam logic ModeFree  = 1'b1;
  localparam logic [AddrW-1:0] AddrOnes = '1;
  localparam int unsigned RandItems = 1030;
  localparam int unsigned LongHold  = 300;

  typedef struct packed {
    logic             mode;
    logic [AddrW-1:0] addr;
  } pool_req_t;

  typedef struct packed {
    status_e           status;
    logic [AddrW-1:0]  addr;
    logic [CountW-1:0] free;
  } pool_rsp_t;

  // DUT ports; the inputs are all known from time zero
  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [AddrW-1:0]   cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               mode = 1'b0;
  logic [AddrW-1:0]   free_address = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         status;
  logic [AddrW-1:0]   block_address;
  logic [CountW-1:0]  blocks_free;

  // Shadow pool: settings and free-list state
  logic [AddrW-1:0]   cfg_base_q;
  logic [ShiftW-1:0]  cfg_shift_q;
  logic [CountW-1:0]  cfg_count_q;
  logic [9:0]         next_link [MaxBlocks];
  logic [9:0]         stack_top;
  logic               stack_nonempty;
  logic [CountW-1:0]  fresh_left;
  logic [CountW-1:0]  free_blocks;
  bit                 in_use [MaxBlocks];
  logic [AddrW-1:0]   live_addrs [$];

  pool_req_t req_pending_q [$];
  pool_rsp_t rsp_expected_q [$];
  pool_req_t next_req;
  pool_rsp_t exp_rsp;

  int unsigned tx_gap = 0;
  int unsigned rx_wait = 0;
  int unsigned rx_draw;
  int unsigned n_results = 0;
  int unsigned long_holds = 0;
  int unsigned n_errors = 0;
  bit          tx_idle = 1'b1;
  bit          rx_idle = 1'b1;
  bit          rand_phase = 1'b0;

  fixed_block_pool_allocator #(
    .MAX_BLOCKS(MaxBlocks)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .mode_i         (mode),
    .free_address_i (free_address),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .status_o       (status),
    .block_address_o(block_address),
    .blocks_free_o  (blocks_free)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Effective settings after clamping
  function automatic int unsigned stride_shift();
    if (cfg_shift_q < ShiftMin) return 32'(ShiftMin);
    if (cfg_shift_q > ShiftMax) return 32'(ShiftMax);
    return 32'(cfg_shift_q);
  endfunction

  function automatic int unsigned pool_blocks();
    return (32'(cfg_count_q) > MaxBlocks) ? MaxBlocks : 32'(cfg_count_q);
  endfunction

  function automatic logic [63:0] pool_origin();
    logic [63:0] stride;
    stride = 64'd1 << stride_shift();
    return {16'd0, cfg_base_q} & ~(stride - 64'd1);
  endfunction

  // Unwrapped byte address of a block index
  function automatic logic [63:0] block_byte_addr(input int unsigned idx);
    logic [63:0] wide_idx;
    wide_idx = 64'(idx);
    return pool_origin() + (wide_idx << stride_shift());
  endfunction

  function automatic void restart_pool();
    for (int i = 0; i < MaxBlocks; i++) in_use[i] = 1'b0;
    stack_top      = '0;
    stack_nonempty = 1'b0;
    fresh_left     = CountW'(pool_blocks());
    free_blocks    = fresh_left;
    live_addrs.delete();
  endfunction

  // Apply one accepted request to the shadow pool, queue its result
  function automatic void predict_result(input logic req_mode, input logic [AddrW-1:0] req_addr);
    int unsigned sh;
    logic [63:0] base, lim, a, ofs, wide;
    logic [9:0]  idx;
    logic        got;
    pool_rsp_t   rsp;
    sh = stride_shift();
    base = pool_origin();
    rsp.status = STATUS_OK;
    rsp.addr = '0;
    got = 1'b0;
    idx = '0;
    if (req_mode == ModeAlloc) begin
      // freed blocks first, then untouched blocks from the top down
      if (stack_nonempty) begin
        idx = stack_top;
        stack_top = next_link[idx];
        free_blocks--;
        stack_nonempty = free_blocks > fresh_left;
        got = 1'b1;
      end else if (fresh_left != '0) begin
        fresh_left--;
        idx = fresh_left[9:0];
        free_blocks--;
        got = 1'b1;
      end
      if (got) begin
        in_use[idx] = 1'b1;
        wide = block_byte_addr(32'(idx));
        rsp.addr = wide[AddrW-1:0];
        live_addrs.push_back(rsp.addr);
      end else begin
        rsp.status = STATUS_EMPTY;
      end
    end else begin
      a = {16'd0, req_addr};
      lim = block_byte_addr(pool_blocks());
      if (a == 64'd0 || a < base || a >= lim ||
          ((a - base) & ((64'd1 << sh) - 64'd1)) != 64'd0) begin
        rsp.status = STATUS_INVALID;
      end else begin
        ofs = (a - base) >> sh;
        idx = ofs[9:0];
        if (!in_use[idx]) begin
          rsp.status = STATUS_DOUBLE;
        end else begin
          in_use[idx] = 1'b0;
          next_link[idx] = stack_top;
          stack_top = idx;
          stack_nonempty = 1'b1;
          free_blocks++;
          for (int k = 0; k < live_addrs.size(); k++) begin
            if (live_addrs[k] == req_addr) begin
              live_addrs.delete(k);
              break;
            end
          end
        end
      end
    end
    rsp.free = free_blocks;
    rsp_expected_q.push_back(rsp);
  endfunction

  // Random request: mostly allocations and frees of blocks in use
  function automatic pool_req_t make_req();
    pool_req_t   r;
    int unsigned pick, idx, sh, n;
    logic [63:0] wide;
    sh = stride_shift();
    n = pool_blocks();
    pick = $urandom_range(0, 99);
    r.mode = ModeFree;
    r.addr = AddrW'({$urandom(), $urandom()});
    if (pick < 45 || (pick < 75 && live_addrs.size() == 0)) begin
      r.mode = ModeAlloc;
    end else if (pick < 75) begin
      r.addr = live_addrs[$urandom_range(0, live_addrs.size() - 1)];
    end else if (pick < 87) begin
      // aligned, may be idle or one past the end
      wide = block_byte_addr($urandom_range(0, n));
      r.addr = wide[AddrW-1:0];
    end else if (pick < 92) begin
      idx = $urandom_range(0, (n == 0) ? 0 : n - 1);
      wide = block_byte_addr(idx) + 64'($urandom_range(1, (1 << sh) - 1));
      r.addr = wide[AddrW-1:0];
    end else if (pick >= 97) begin
      case ($urandom_range(0, 2))
        0: r.addr = '0;
        1: r.addr = AddrOnes;
        default: begin
          wide = pool_origin() - (64'd1 << sh);
          r.addr = wide[AddrW-1:0];
        end
      endcase
    end
    return r;
  endfunction

  function automatic pool_req_t req(input logic m, input logic [AddrW-1:0] a);
    pool_req_t r;
    r.mode = m;
    r.addr = a;
    return r;
  endfunction

  task automatic write_reg(input reg_idx_e idx, input logic [AddrW-1:0] value);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      REG_POOL_BASE:   cfg_base_q  = value;
      REG_STRIDE_LOG2: cfg_shift_q = value[ShiftW-1:0];
      REG_BLOCK_COUNT: cfg_count_q = value[CountW-1:0];
      default: ;
    endcase
    restart_pool();
  endtask

  // Hold until every queued request is accepted and every result is back
  task automatic wait_drained();
    @(negedge clk_i);
    while (req_pending_q.size() != 0 || in_valid || rsp_expected_q.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic check_result();
    if (rsp_expected_q.size() == 0) begin
      $error("unexpected result: status %0d address %h free %0d",
             status, block_address, blocks_free);
      n_errors++;
    end else begin
      exp_rsp = rsp_expected_q.pop_front();
      if (status !== exp_rsp.status) begin
        $error("status: expected %0d, got %0d", exp_rsp.status, status);
        n_errors++;
      end
      if (block_address !== exp_rsp.addr) begin
        $error("block_address: expected %h, got %h", exp_rsp.addr, block_address);
        n_errors++;
      end
      if (blocks_free !== exp_rsp.free) begin
        $error("blocks_free: expected %0d, got %0d", exp_rsp.free, blocks_free);
        n_errors++;
      end
    end
  endtask

  // Request driver: random gaps while tx_idle is set, payload held until transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid     <= 1'b0;
      mode         <= ModeAlloc;
      free_address <= '0;
      tx_gap       <= 0;
    end else begin
      if (in_valid && in_ready) predict_result(mode, free_address);
      if (!in_valid || in_ready) begin
        if (tx_gap != 0) begin
          tx_gap   <= tx_gap - 1;
          in_valid <= 1'b0;
        end else if (req_pending_q.size() != 0) begin
          next_req = req_pending_q.pop_front();
          mode         <= next_req.mode;
          free_address <= next_req.addr;
          in_valid     <= 1'b1;
          tx_gap       <= tx_idle ? $urandom_range(0, 5) : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each transfer, then stalls for a drawn count
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
      rx_wait   <= 0;
    end else begin
      if (out_valid && out_ready) begin
        check_result();
        n_results++;
        // two long holds so the pipe backs up into the input
        if (rand_phase && long_holds < 2 &&
            n_results >= ((long_holds == 0) ? 150 : 600)) begin
          rx_draw = LongHold;
          long_holds++;
        end else begin
          rx_draw = rx_idle ? $urandom_range(0, 5) : 0;
        end
        if (rx_draw == 0) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b0;
          rx_wait   <= rx_draw;
        end
      end else if (rx_wait > 1) begin
        rx_wait <= rx_wait - 1;
      end else begin
        rx_wait   <= 0;
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    #3_000_000;
    $display("[fixed_block_pool_allocator] ERROR");
    $finish;
  end

  initial begin
    int unsigned rand_left, n_items, ph;
    bit          wr_base, wr_shift, wr_count;
    logic [AddrW-1:0] new_base;

    cfg_base_q  = '0;
    cfg_shift_q = ShiftW'(6);
    cfg_count_q = CountW'(1024);
    restart_pool();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Default pool: base 0, 64-byte stride, 1024 blocks
    req_pending_q.push_back(req(ModeFree, '0));             // null, block zero at 0
    req_pending_q.push_back(req(ModeFree, AddrOnes));
    req_pending_q.push_back(req(ModeAlloc, '0));
    req_pending_q.push_back(req(ModeAlloc, AddrOnes));
    req_pending_q.push_back(req(ModeFree, 48'h0000_0000_FFC8));  // misaligned
    req_pending_q.push_back(req(ModeFree, 48'h0000_0000_FF80));
    req_pending_q.push_back(req(ModeFree, 48'h0000_0000_FF80));  // double free
    req_pending_q.push_back(req(ModeFree, 48'h0000_0000_0140));  // never handed out
    req_pending_q.push_back(req(ModeAlloc, '0));                 // reuses last freed
    req_pending_q.push_back(req(ModeFree, 48'h0000_0001_0000));  // one past the end
    wait_drained();

    // Unaligned base near the top, stride below range, count above range
    write_reg(REG_POOL_BASE, 48'hFFFF_FFFF_FFC5);
    write_reg(REG_STRIDE_LOG2, '0);
    write_reg(REG_BLOCK_COUNT, 48'd2047);
    req_pending_q.push_back(req(ModeAlloc, '0));                 // address wraps
    req_pending_q.push_back(req(ModeFree, 48'h0000_0000_1FB8));  // wrapped, not freeable
    req_pending_q.push_back(req(ModeFree, 48'hFFFF_FFFF_FFC0));
    req_pending_q.push_back(req(ModeFree, 48'hFFFF_FFFF_FFC5));
    req_pending_q.push_back(req(ModeFree, 48'hFFFF_FFFF_FFB8));
    wait_drained();

    // Zero-size pool
    write_reg(REG_BLOCK_COUNT, '0);
    req_pending_q.push_back(req(ModeAlloc, '0));
    req_pending_q.push_back(req(ModeFree, 48'hFFFF_FFFF_FFC0));
    wait_drained();

    // Single block, stride above range
    write_reg(REG_POOL_BASE, 48'h1234_5678_0000);
    write_reg(REG_STRIDE_LOG2, 48'd31);
    write_reg(REG_BLOCK_COUNT, 48'd1);
    req_pending_q.push_back(req(ModeAlloc, '0));
    req_pending_q.push_back(req(ModeAlloc, '0));
    req_pending_q.push_back(req(ModeFree, 48'h1234_5678_0000));
    req_pending_q.push_back(req(ModeFree, 48'h1234_5678_0000));
    req_pending_q.push_back(req(ModeAlloc, '0));
    req_pending_q.push_back(req(ModeFree, 48'h1234_5679_0000));
    wait_drained();

    // Random phases, each under its own pool setting
    rand_left = RandItems;
    ph = 0;
    while (rand_left > 0) begin
      if (ph == 0) begin
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        write_reg(REG_POOL_BASE, '0);
        write_reg(REG_STRIDE_LOG2, AddrW'(ShiftMin));
        write_reg(REG_BLOCK_COUNT, 48'd1024);
      end else if (ph == 1) begin
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        write_reg(REG_POOL_BASE, AddrOnes);
        write_reg(REG_STRIDE_LOG2, AddrW'(ShiftMax));
        write_reg(REG_BLOCK_COUNT, 48'd1024);
      end else begin
        tx_idle = $urandom_range(0, 3) != 0;
        rx_idle = $urandom_range(0, 3) != 0;
        wr_base  = $urandom_range(0, 2) != 0;
        wr_shift = $urandom_range(0, 2) != 0;
        wr_count = !(wr_base || wr_shift) || $urandom_range(0, 2) != 0;
        if (wr_base) begin
          case ($urandom_range(0, 3))
            0: new_base = '0;
            1: new_base = AddrW'({$urandom(), $urandom()});
            2: new_base = AddrOnes;
            default: new_base = {16'd0, $urandom()};
          endcase
          write_reg(REG_POOL_BASE, new_base);
        end
        if (wr_shift)
          write_reg(REG_STRIDE_LOG2, AddrW'(($urandom_range(0, 9) == 0) ?
                    $urandom_range(0, 31) : $urandom_range(3, 16)));
        if (wr_count) begin
          case ($urandom_range(0, 9))
            7: write_reg(REG_BLOCK_COUNT, '0);
            8: write_reg(REG_BLOCK_COUNT, AddrW'($urandom_range(1024, 2047)));
            9: write_reg(REG_BLOCK_COUNT, AddrW'($urandom_range(13, 1024)));
            default: write_reg(REG_BLOCK_COUNT, AddrW'($urandom_range(1, 12)));
          endcase
        end
      end
      n_items = $urandom_range(40, 140);
      if (n_items > rand_left) n_items = rand_left;
      @(negedge clk_i);
      rand_phase = 1'b1;
      // keep the request queue shallow so live addresses stay current
      for (int k = 0; k < n_items; k++) begin
        while (req_pending_q.size() >= 4) @(negedge clk_i);
        req_pending_q.push_back(make_req());
      end
      rand_phase = 1'b0;
      rand_left -= n_items;
      ph++;
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("[fixed_block_pool_allocator] OK");
    end else begin
      $display("[fixed_block_pool_allocator] ERROR");
    end
    $finish;
  end

endmodule

// ===== fixed_block_pool_allocator.f =====
rtl/core/fbpa_pkg.sv
rtl/core/fbpa_ram.sv
rtl/core/fbpa_ctrl.sv
rtl/core/fbpa_dp.sv
rtl/core/fixed_block_pool_allocator.sv
verif/tb.sv
